// ===== rtl/kae_pkg.sv =====
// Shared types and constants for the key autorepeat event generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package kae_pkg;

    // Per-tick output limit and the width of the counter that tracks it
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    localparam int CFG_W       = 16;
    localparam int HELD_W      = 16;
    localparam int KEY_IDX_W   = 4;

    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_REPEAT = 2'd1,
        EV_UP     = 2'd2,
        EV_CLICK  = 2'd3
    } event_kind_t;

    // Register map, word index
    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_CLICK  = 2'd2;
    localparam logic [1:0] REG_SKIP   = 2'd3;

    localparam logic [CFG_W-1:0] DELAY_RST  = 16'd30;
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd5;
    localparam logic [CFG_W-1:0] CLICK_RST  = 16'd30;
    localparam logic [CFG_W-1:0] SKIP_RST   = 16'h3000;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_period;
        logic [CFG_W-1:0] click_limit;
        logic [CFG_W-1:0] skip_mask;
    } kae_cfg_t;

    // Controller -> datapath
    typedef struct packed {
        logic        capture;
        logic        key_next;
        logic        push;
        event_kind_t kind;
        logic        cnt_inc;
        logic        cnt_clr;
        logic        mod_start;
        logic        flush;
    } kae_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic skip;
        logic held;
        logic c_zero;
        logic rep_cand;
        logic click;
        logic last_key;
        logic push_ok;
        logic flush_ok;
        logic pend_valid;
        logic n_full;
        logic mod_done;
        logic mod_zero;
    } kae_status_t;

endpackage

`default_nettype wire

// ===== rtl/kae_mod_unit.sv =====
// Iterative remainder unit: count modulo period, four quotient bits per cycle.
// Depends on kae_pkg.
`default_nettype none

module kae_mod_unit
    import kae_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [COUNT_WIDTH-1:0] dividend,
    input  wire logic [CFG_W-1:0]       divisor,
    output logic                        done,
    output logic                        rem_zero
);

    localparam int DW    = ((COUNT_WIDTH + 3) / 4) * 4;
    localparam int STEPS = DW / 4;
    localparam int SW    = $clog2(STEPS) + 1;

    logic [DW-1:0]    dvd_reg;
    logic [CFG_W-1:0] div_reg;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [SW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;

    // Four restoring steps; remainder stays below 2*divisor, so 17 bits suffice
    always_comb begin
        logic [CFG_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < 4; i++) begin
            r = {r[CFG_W-1:0], dvd_reg[DW-1-i]};
            if (r >= {1'b0, div_reg}) begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[CFG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= SW'(STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= DW'(dividend);
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DW-5:0], 4'b0000};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/kae_datapath.sv =====
// Datapath: held counters, key walk, event pending stage and output register.
// Depends on kae_pkg and kae_mod_unit.
`default_nettype none

module kae_datapath
    import kae_pkg::*;
#(
    parameter int KEY_COUNT   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire kae_cfg_t             cfg,
    input  wire kae_cmd_t             cmd,
    output kae_status_t               st,
    input  wire logic [HELD_W-1:0]    s_held_keys,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [KEY_IDX_W-1:0]      m_key_index,
    output logic [1:0]                m_event_kind,
    output logic                      m_last_event
);

    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [COUNT_WIDTH-1:0] count_reg [KEY_COUNT];
    logic [HELD_W-1:0]      keys_reg;
    logic [KW-1:0]          key_reg;
    logic [RES_CNT_W-1:0]   n_reg;

    logic                   pend_valid_reg;
    logic [KEY_IDX_W-1:0]   pend_key_reg;
    event_kind_t            pend_kind_reg;

    logic                   m_valid_reg;
    logic [KEY_IDX_W-1:0]   m_key_reg;
    event_kind_t            m_kind_reg;
    logic                   m_last_reg;

    logic [COUNT_WIDTH-1:0] c;
    logic [31:0]            key_ext, c_ext;
    logic                   in_range, out_free, n_full;
    logic                   take_push, load_push, load_flush;
    logic                   mod_done, mod_zero;

    assign key_ext  = 32'(key_reg);
    assign in_range = key_ext < 32'(HELD_W);
    assign c        = count_reg[key_reg];
    assign c_ext    = 32'(c);

    assign out_free = !m_valid_reg || m_ready;
    assign n_full   = (n_reg == RES_CNT_W'(MAX_RESULTS));

    assign st.skip       = in_range && cfg.skip_mask[key_ext[3:0]];
    assign st.held       = in_range && keys_reg[key_ext[3:0]];
    assign st.c_zero     = (c == '0);
    assign st.rep_cand   = (cfg.repeat_delay != '0) && (cfg.repeat_period != '0) &&
                           (c_ext > 32'(cfg.repeat_delay));
    assign st.click      = c_ext < 32'(cfg.click_limit);
    assign st.last_key   = (key_reg == KW'(KEY_COUNT - 1));
    assign st.push_ok    = n_full || !pend_valid_reg || out_free;
    assign st.flush_ok   = out_free;
    assign st.pend_valid = pend_valid_reg;
    assign st.n_full     = n_full;
    assign st.mod_done   = mod_done;
    assign st.mod_zero   = mod_zero;

    // Events past the per-tick limit are dropped
    assign take_push  = cmd.push && st.push_ok && !n_full;
    assign load_push  = take_push && pend_valid_reg;
    assign load_flush = cmd.flush && out_free && pend_valid_reg;

    kae_mod_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (c),
        .divisor  (cfg.repeat_period),
        .done     (mod_done),
        .rem_zero (mod_zero)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                count_reg[k] <= '0;
            end
            key_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.capture) begin
                key_reg <= '0;
                n_reg   <= '0;
            end else if (cmd.key_next) begin
                key_reg <= key_reg + 1'b1;
            end

            if (cmd.cnt_inc) begin
                count_reg[key_reg] <= c + 1'b1;
            end else if (cmd.cnt_clr) begin
                count_reg[key_reg] <= '0;
            end

            if (take_push) begin
                n_reg          <= n_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end else if (load_flush) begin
                pend_valid_reg <= 1'b0;
            end

            if (load_push || load_flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            keys_reg <= s_held_keys;
        end
        if (take_push) begin
            pend_key_reg  <= key_ext[KEY_IDX_W-1:0];
            pend_kind_reg <= cmd.kind;
        end
        if (load_push || load_flush) begin
            m_key_reg  <= pend_key_reg;
            m_kind_reg <= pend_kind_reg;
            m_last_reg <= load_flush;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_key_index  = m_key_reg;
    assign m_event_kind = m_kind_reg;
    assign m_last_event = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/kae_ctrl.sv =====
// Controller: walks the keys of one tick and sequences events and counter updates.
// Depends on kae_pkg.
`default_nettype none

module kae_ctrl
    import kae_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire kae_status_t st,
    output kae_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_MOD,
        ST_DOWN,
        ST_REP,
        ST_UP,
        ST_CLICK,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = EV_DOWN;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_ready_reg && s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_KEY;
                end
            end
            ST_KEY: begin
                priority if (st.skip) begin
                    cmd.key_next = 1'b1;
                    state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                end else if (st.held && st.c_zero) begin
                    state_next = ST_DOWN;
                end else if (st.held && st.rep_cand) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end else if (st.held) begin
                    cmd.cnt_inc  = 1'b1;
                    cmd.key_next = 1'b1;
                    state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                end else if (!st.c_zero) begin
                    state_next = ST_UP;
                end else begin
                    cmd.key_next = 1'b1;
                    state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                end
            end
            ST_MOD: begin
                if (st.mod_done) begin
                    if (st.mod_zero) begin
                        state_next = ST_REP;
                    end else begin
                        cmd.cnt_inc  = 1'b1;
                        cmd.key_next = 1'b1;
                        state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                    end
                end
            end
            ST_DOWN, ST_REP: begin
                cmd.push = 1'b1;
                cmd.kind = (state_reg == ST_DOWN) ? EV_DOWN : EV_REPEAT;
                if (st.push_ok) begin
                    cmd.cnt_inc  = 1'b1;
                    cmd.key_next = 1'b1;
                    state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                end
            end
            ST_UP: begin
                cmd.push = 1'b1;
                cmd.kind = EV_UP;
                if (st.push_ok) begin
                    if (st.click) begin
                        state_next = ST_CLICK;
                    end else begin
                        cmd.cnt_clr  = 1'b1;
                        cmd.key_next = 1'b1;
                        state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                    end
                end
            end
            ST_CLICK: begin
                cmd.push = 1'b1;
                cmd.kind = EV_CLICK;
                if (st.push_ok) begin
                    cmd.cnt_clr  = 1'b1;
                    cmd.key_next = 1'b1;
                    state_next   = st.last_key ? ST_FLUSH : ST_KEY;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (!st.pend_valid || st.flush_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

// ===== rtl/key_autorepeat_event_generator.sv =====
// Key autorepeat event generator: top level with APB register block and assertions.
// Depends on kae_pkg, kae_ctrl and kae_datapath.
//
// Each request on the s_ channel is one frame tick carrying the held-key bitmap.
// Keys are visited from 0 upward; keys set in skip_mask are passed over. A held
// key with a zero count gives key-down; a held key whose count exceeds
// repeat_delay and is a multiple of repeat_period gives repeat (zero delay or
// zero period disables repeat); the count then increments, wrapping at
// COUNT_WIDTH bits. A released key with a nonzero count gives key-up, then
// click when the count is below click_limit, and its count clears. Results
// leave in key order on the m_ channel, at most 32 per tick, with
// m_last_event marking the final one; a quiet tick gives none. The walk
// visits the keys one by one, takes a further state for every event, and
// for every held key past the delay (with repeat enabled) runs a remainder
// calculation in the shared four-bit-per-cycle remainder unit, then ends
// with the final flush and return to idle. An unclaimed result stalls the
// walk once the one-entry pending stage is full. Configuration registers sit
// at byte addresses 0, 4, 8, 12 (delay, period, click limit, skip mask) and
// are to be written only while the block is idle.
`default_nettype none

module key_autorepeat_event_generator
    import kae_pkg::*;
#(
    parameter int KEY_COUNT   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // tick input
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [HELD_W-1:0]    s_held_keys,
    // event output
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [KEY_IDX_W-1:0]      m_key_index,
    output logic [1:0]                m_event_kind,
    output logic                      m_last_event,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    kae_cfg_t    cfg_reg;
    kae_cmd_t    cmd;
    kae_status_t st;
    logic        cfg_wr;

    // ---------------- register block ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_delay  <= DELAY_RST;
            cfg_reg.repeat_period <= PERIOD_RST;
            cfg_reg.click_limit   <= CLICK_RST;
            cfg_reg.skip_mask     <= SKIP_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DELAY:  cfg_reg.repeat_delay  <= pwdata[CFG_W-1:0];
                REG_PERIOD: cfg_reg.repeat_period <= pwdata[CFG_W-1:0];
                REG_CLICK:  cfg_reg.click_limit   <= pwdata[CFG_W-1:0];
                REG_SKIP:   cfg_reg.skip_mask     <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DELAY:  prdata = 32'(cfg_reg.repeat_delay);
            REG_PERIOD: prdata = 32'(cfg_reg.repeat_period);
            REG_CLICK:  prdata = 32'(cfg_reg.click_limit);
            REG_SKIP:   prdata = 32'(cfg_reg.skip_mask);
            default:    prdata = '0;
        endcase
    end

    // ---------------- controller ----------------
    kae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // ---------------- datapath ----------------
    kae_datapath #(
        .KEY_COUNT   (KEY_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .st           (st),
        .s_held_keys  (s_held_keys),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_index  (m_key_index),
        .m_event_kind (m_event_kind),
        .m_last_event (m_last_event)
    );

    // ---------------- assertions ----------------
    // A kept event arriving behind a pending one moves that one to the output
    a_push_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push && st.push_ok && st.pend_valid && !st.n_full |=> m_valid)
        else $error("pending event not moved to output");

    // The pending stage is always flushed before the next tick is taken
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !st.pend_valid)
        else $error("tick accepted with an event still pending");

    // A fresh remainder request never reports a stale result
    a_mod_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_start |=> !st.mod_done)
        else $error("remainder unit reports done right after start");

    // A final result is only produced by the flush at the end of a tick
    a_last_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_event && !$stable(m_valid) |-> $past(cmd.flush))
        else $error("last_event raised outside the end-of-tick flush");

endmodule

`default_nettype wire

// ===== test/tb_key_autorepeat_event_generator.sv =====
// Self-checking testbench for key_autorepeat_event_generator: frame ticks in, key events out.
// Depends on kae_pkg and the block's RTL; holds its own model of the per-key counters.

module tb_key_autorepeat_event_generator;
    import kae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2000000;
    // Settle wait after a drain; covers the walk of the busiest tick, flush included
    localparam int SETTLE_TICKS = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [KEY_IDX_W-1:0] key;
        event_kind_t          kind;
        logic                 last;
    } key_event_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // tick channel
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [HELD_W-1:0] s_held_keys = '0;

    // event channel
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [KEY_IDX_W-1:0] m_key_index;
    logic [1:0]           m_event_kind;
    logic                 m_last_event;

    // register port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state: register copies and per-key held-frame counters
    logic [CFG_W-1:0] cfg_delay  = DELAY_RST;
    logic [CFG_W-1:0] cfg_period = PERIOD_RST;
    logic [CFG_W-1:0] cfg_click  = CLICK_RST;
    logic [CFG_W-1:0] cfg_skip   = SKIP_RST;
    bit [31:0]        held_frames [16];

    logic [HELD_W-1:0] tick_backlog [$];     // ticks still to be offered
    key_event_t        pending_events [$];   // events predicted, not yet seen
    int unsigned       ticks_queued   = 0;
    int unsigned       ticks_accepted = 0;
    int unsigned       mismatches     = 0;
    int unsigned       cycle_count    = 0;

    // random held-key pattern carried from phase to phase
    logic [HELD_W-1:0] held_pattern = '0;

    // traffic shaping, set from the sequence below
    bit steady  = 1'b0;   // no idling on either side
    bit hold_go = 1'b0;   // ask the receiver for one long hold-off

    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    key_autorepeat_event_generator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_held_keys  (s_held_keys),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_index  (m_key_index),
        .m_event_kind (m_event_kind),
        .m_last_event (m_last_event),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Walk keys 0..15 for one tick, advance the counters and queue the
    // events the block must produce, in key order, up before click.
    function automatic void predict_key_events(input logic [HELD_W-1:0] keys);
        key_event_t evs [$];
        bit [31:0]  c;
        for (int k = 0; k < 16; k++) begin
            c = held_frames[k];
            // skipped key: no event and the counter is left alone
            if (cfg_skip[k])
                continue;
            if (keys[k]) begin
                if (c == 0) begin
                    if (evs.size() < MAX_RESULTS)
                        evs.push_back('{KEY_IDX_W'(k), EV_DOWN, 1'b0});
                end else if (cfg_delay != 0 && cfg_period != 0 &&
                             c > cfg_delay && (c % cfg_period) == 0) begin
                    if (evs.size() < MAX_RESULTS)
                        evs.push_back('{KEY_IDX_W'(k), EV_REPEAT, 1'b0});
                end
                held_frames[k] = c + 1;
            end else if (c != 0) begin
                if (evs.size() < MAX_RESULTS)
                    evs.push_back('{KEY_IDX_W'(k), EV_UP, 1'b0});
                if (c < cfg_click && evs.size() < MAX_RESULTS)
                    evs.push_back('{KEY_IDX_W'(k), EV_CLICK, 1'b0});
                held_frames[k] = 0;
            end
        end
        if (evs.size() > 0)
            evs[evs.size()-1].last = 1'b1;
        foreach (evs[i])
            pending_events.push_back(evs[i]);
    endfunction

    // Tick driver: predicts on acceptance, then offers the next backlog entry
    // unless it decides to idle this cycle.
    always @(posedge aclk) begin : tick_driver
        bit busy;
        busy = s_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_key_events(s_held_keys);
                ticks_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (tick_backlog.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
                    s_held_keys <= tick_backlog.pop_front();
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness, with one long hold-off counted here so the block
    // backs up and stops taking ticks.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || $urandom_range(99) >= 6;
        end
    end

    // Event monitor: every accepted event against the oldest prediction
    always @(posedge aclk) begin : event_monitor
        key_event_t  want;
        event_kind_t got_kind;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event: expected none, got key %0d kind %0d last %0b",
                         $time, m_key_index, m_event_kind, m_last_event);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                if (m_key_index !== want.key || m_event_kind !== want.kind ||
                    m_last_event !== want.last) begin
                    got_kind = event_kind_t'(m_event_kind);
                    $display("%0t: expected key %0d %s last %0b, got key %0d %s last %0b",
                             $time, want.key, want.kind.name(), want.last,
                             m_key_index, got_kind.name(), m_last_event);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // APB write: setup cycle, then access; model copy follows on the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        logic [15:0] junk;
        junk = 16'($urandom());   // upper half is ignored by the block
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DELAY:  cfg_delay  = val;
            REG_PERIOD: cfg_period = val;
            REG_CLICK:  cfg_click  = val;
            REG_SKIP:   cfg_skip   = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] period,
                              input logic [CFG_W-1:0] click, input logic [CFG_W-1:0] skip);
        write_reg(REG_DELAY, delay);
        write_reg(REG_PERIOD, period);
        write_reg(REG_CLICK, click);
        write_reg(REG_SKIP, skip);
    endtask

    task automatic queue_tick(input logic [HELD_W-1:0] keys);
        tick_backlog.push_back(keys);
        ticks_queued++;
    endtask

    // Wait for every tick to go in and every event to come out, then let a
    // trailing quiet tick finish its walk before anything else is touched.
    task automatic drain;
        @(posedge aclk);
        while (ticks_accepted != ticks_queued || pending_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Mostly held-key runs: each key flips with odds 1 in flip_odds per tick,
    // so holds last long enough to reach repeats; one tick in ten is noise.
    task automatic queue_random(input int n, input int flip_odds);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                queue_tick(HELD_W'($urandom()));
            end else begin
                for (int b = 0; b < HELD_W; b++)
                    if ($urandom_range(flip_odds - 1) == 0)
                        held_pattern[b] = ~held_pattern[b];
                queue_tick(held_pattern);
            end
        end
    endtask

    initial begin
        foreach (held_frames[k])
            held_frames[k] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: keys 12 and 13 are skipped, repeats far away
        queue_tick(16'hFFFF);
        queue_tick(16'hFFFF);
        queue_tick(16'h0000);
        queue_tick(16'hFFFF);
        drain();

        // directed: delay boundary, repeat, up with and without click,
        // a full 32-event tick, quiet ticks, alternating bits
        set_config(16'd2, 16'd2, 16'd3, 16'h0000);
        queue_tick(16'h0000);
        queue_tick(16'hFFFF);   // all down (keys 12/13 were skipped, counts zero)
        queue_tick(16'hFFFF);
        queue_tick(16'hFFFF);   // count equals delay: no repeat
        queue_tick(16'hFFFF);   // past delay, odd count
        queue_tick(16'hFFFF);   // repeat on every key
        queue_tick(16'h0000);   // up, count too high for click
        queue_tick(16'hFFFF);
        queue_tick(16'h0000);   // up and click on every key
        queue_tick(16'h8001);
        queue_tick(16'h8001);
        queue_tick(16'h0001);   // key 15 released early
        queue_tick(16'h0001);
        queue_tick(16'h0000);   // key 0 up, count past the click limit
        queue_tick(16'hAAAA);
        queue_tick(16'h5555);
        queue_tick(16'hAAAA);
        queue_tick(16'h0000);
        drain();

        // busy phase with one long receiver hold-off while ticks keep coming
        set_config(16'd3, 16'd2, 16'd4, 16'h0000);
        hold_go = 1'b1;
        queue_random(45, 6);
        drain();

        // no idling on either side, fastest repeat, every release clicks
        steady = 1'b1;
        set_config(16'd1, 16'd1, 16'hFFFF, 16'h0000);
        queue_random(45, 4);
        drain();
        steady = 1'b0;

        // zero delay, no clicks, low keys skipped with counts kept
        set_config(16'd0, 16'd3, 16'd0, 16'h00FF);
        queue_random(40, 8);
        drain();

        // zero period, high keys skipped
        set_config(16'd4, 16'd0, 16'd2, 16'hFF00);
        queue_random(40, 8);
        drain();

        // largest delay and period, random mask
        set_config(16'hFFFF, 16'hFFFF, 16'd5, 16'($urandom()));
        queue_random(40, 3);
        drain();

        // everything skipped: quiet ticks only
        set_config(16'd5, 16'd3, 16'd7, 16'hFFFF);
        queue_random(12, 4);
        drain();

        // random small settings, sparse masks, short and long holds
        set_config(16'($urandom_range(8)), 16'($urandom_range(4)), 16'($urandom_range(10)),
                   16'($urandom() & $urandom() & $urandom()));
        queue_random(50, 10);
        drain();

        set_config(16'($urandom_range(8)), 16'($urandom_range(4)), 16'($urandom_range(10)),
                   16'($urandom() & $urandom() & $urandom()));
        queue_random(50, 16);
        drain();

        set_config(16'($urandom_range(1, 3)), 16'($urandom_range(1, 2)),
                   16'($urandom_range(65535)), 16'h0000);
        queue_random(40, 6);
        drain();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
